### design/ddo_pkg.sv
// Shared types, constants and tables for the differential-drive odometry core.
package ddo_pkg;

  localparam int AW    = 72;
  localparam int QW    = 40;
  localparam int MBW   = 36;
  localparam int SH_W  = 6;
  localparam int CW    = 34;
  localparam int IDX_W = 8;

  localparam logic [IDX_W-1:0] REG_AXLE_LENGTH   = 8'd0;
  localparam logic [IDX_W-1:0] REG_START_X       = 8'd1;
  localparam logic [IDX_W-1:0] REG_START_Y       = 8'd2;
  localparam logic [IDX_W-1:0] REG_START_HEADING = 8'd3;

  localparam logic [15:0] AXLE_RESET = 16'd3072;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd326016437;
  localparam logic signed [AW-1:0] RAD_TO_BAM  = 72'sd683565276;
  localparam logic [SH_W-1:0] SHIFT_HEADING = 6'd32;
  localparam logic [SH_W-1:0] SHIFT_ARC     = 6'd30;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [15:0] new_heading;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } op_t;

  typedef struct packed {
    logic                 start;
    op_t                  op;
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] b;
    logic [SH_W-1:0]      shift;
  } md_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [AW-1:0] result;
  } md_resp_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
  } cor_resp_t;

  function automatic logic [31:0] atan_at(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### design/differential_drive_odometry_step_core.sv
// Top level: pose sequencer, configuration registers and result register.
//
// Dead-reckoning pose update for a two-wheel vehicle. An input transfer on
// in_valid/in_stall carries the wheel speeds and the time step; one result
// transfer on out_valid/out_stall returns the updated x, y and heading.
// Configuration is to be written through cfg_write/cfg_index/cfg_data while
// idle, which the block does not enforce; writing a start register also
// loads the matching pose value at once. in_stall is high from acceptance
// until the result has been loaded into the output register, so one item is
// in work at a time. Equal speeds need one CORDIC pass and two bit-serial
// multiplies; a turn needs two passes, three multiplies and three divides.
// The next input is taken in the cycle after the result is loaded.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile but its result waits for that slot.
// Reset (synchronous, rst) clears the pose to zero, sets the axle length to
// 3072 and empties the output register.
module differential_drive_odometry_step_core #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ddo_pkg::IDX_W-1:0]       cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ddo_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ddo_pkg::out_item_t              out_data
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_COS0 = 12'b000000000010,
    S_SMX  = 12'b000000000100,
    S_SMY  = 12'b000000001000,
    S_TMUL = 12'b000000010000,
    S_TDIV = 12'b000000100000,
    S_COS1 = 12'b000001000000,
    S_KMX  = 12'b000010000000,
    S_KDX  = 12'b000100000000,
    S_KMY  = 12'b001000000000,
    S_KDY  = 12'b010000000000,
    S_UPD  = 12'b100000000000
  } state_t;

  localparam int AW = ddo_pkg::AW;
  localparam int CW = ddo_pkg::CW;

  state_t state, state_next;
  logic   launch;

  logic [15:0]        axle;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_heading;

  logic signed [15:0] l;
  logic signed [15:0] r;
  logic               straight;
  logic signed [33:0] prod;
  logic signed [33:0] k;
  logic signed [15:0] hn;
  logic signed [CW-1:0] c0, s0, c1, s1;
  logic signed [AW-1:0] tmp;
  logic signed [39:0]   dx;
  logic signed [39:0]   dy;

  ddo_pkg::md_req_t   md_req;
  ddo_pkg::md_resp_t  md_resp;
  ddo_pkg::cor_req_t  cor_req;
  ddo_pkg::cor_resp_t cor_resp;

  logic               accept;
  logic               out_free;
  logic               unit_done;
  logic signed [16:0] diff_in;
  logic signed [16:0] fac_in;
  logic signed [16:0] dt_in;
  logic signed [33:0] prod_in;
  logic [15:0]        axle_eff;
  logic signed [16:0] diff_r;
  logic signed [16:0] sum_r;
  logic signed [AW-1:0] round_p;
  logic signed [AW-1:0] shr_p;
  logic signed [40:0] sum_x;
  logic signed [40:0] sum_y;
  logic signed [31:0] sat_x;
  logic signed [31:0] sat_y;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign diff_in  = 17'(in_data.left_speed) - 17'(in_data.right_speed);
  assign fac_in   = (diff_in == 17'sd0) ? 17'(in_data.right_speed) : diff_in;
  assign dt_in    = {1'b0, in_data.time_step};
  assign prod_in  = 34'(fac_in) * 34'(dt_in);
  assign axle_eff = (axle == 16'd0) ? 16'd1 : axle;
  assign diff_r   = 17'(l) - 17'(r);
  assign sum_r    = 17'(l) + 17'(r);

  assign round_p = md_resp.result + (AW'(1) <<< 44);
  assign shr_p   = round_p >>> 45;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] o;
    if (v[40:31] != {10{v[31]}}) begin
      o = v[40] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  assign sum_x = 41'(pose_x) + 41'(dx);
  assign sum_y = 41'(pose_y) + 41'(dy);
  assign sat_x = sat32(sum_x);
  assign sat_y = sat32(sum_y);

  assign unit_done = ((state == S_COS0) || (state == S_COS1)) ? cor_resp.done : md_resp.done;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_COS0;
      S_COS0: if (unit_done) state_next = straight ? S_SMX : S_TMUL;
      S_SMX:  if (unit_done) state_next = S_SMY;
      S_SMY:  if (unit_done) state_next = S_UPD;
      S_TMUL: if (unit_done) state_next = S_TDIV;
      S_TDIV: if (unit_done) state_next = S_COS1;
      S_COS1: if (unit_done) state_next = S_KMX;
      S_KMX:  if (unit_done) state_next = S_KDX;
      S_KDX:  if (unit_done) state_next = S_KMY;
      S_KMY:  if (unit_done) state_next = S_KDY;
      S_KDY:  if (unit_done) state_next = S_UPD;
      S_UPD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cor_req.start = launch && ((state == S_COS0) || (state == S_COS1));
    cor_req.angle = (state == S_COS1) ? hn : pose_heading;
    md_req.start  = launch && (state != S_COS0) && (state != S_COS1);
    md_req.op     = ddo_pkg::OP_MUL;
    md_req.a      = '0;
    md_req.b      = '0;
    md_req.shift  = '0;
    case (state)
      S_SMX: begin
        md_req.a = AW'(c0);
        md_req.b = AW'(prod);
      end
      S_SMY: begin
        md_req.a = AW'(s0);
        md_req.b = AW'(prod);
      end
      S_TMUL: begin
        md_req.a = ddo_pkg::RAD_TO_BAM;
        md_req.b = AW'(prod);
      end
      S_TDIV: begin
        md_req.op    = ddo_pkg::OP_DIV;
        md_req.a     = tmp;
        md_req.b     = AW'(signed'({1'b0, axle_eff}));
        md_req.shift = ddo_pkg::SHIFT_HEADING;
      end
      S_KMX: begin
        md_req.a = AW'(s1) - AW'(s0);
        md_req.b = AW'(k);
      end
      S_KMY: begin
        md_req.a = AW'(c0) - AW'(c1);
        md_req.b = AW'(k);
      end
      S_KDX, S_KDY: begin
        md_req.op    = ddo_pkg::OP_DIV;
        md_req.a     = tmp;
        md_req.b     = AW'(diff_r);
        md_req.shift = ddo_pkg::SHIFT_ARC;
      end
      default: ;
    endcase
  end

  ddo_cordic #(
    .ITER(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (cor_req),
    .resp (cor_resp)
  );

  ddo_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .resp (md_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      launch       <= 1'b0;
      out_valid    <= 1'b0;
      axle         <= ddo_pkg::AXLE_RESET;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      state  <= state_next;
      launch <= (state_next != state) && (state_next != S_IDLE) && (state_next != S_UPD);

      if (cfg_write) begin
        case (cfg_index)
          ddo_pkg::REG_AXLE_LENGTH:   axle         <= cfg_data[15:0];
          ddo_pkg::REG_START_X:       pose_x       <= cfg_data;
          ddo_pkg::REG_START_Y:       pose_y       <= cfg_data;
          ddo_pkg::REG_START_HEADING: pose_heading <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (accept) begin
        l        <= in_data.left_speed;
        r        <= in_data.right_speed;
        straight <= (diff_in == 17'sd0);
        prod     <= prod_in;
        hn       <= pose_heading;
      end

      if (state == S_COS0) k <= 34'(signed'({1'b0, axle_eff})) * 34'(sum_r);

      if (unit_done) begin
        case (state)
          S_COS0: begin
            c0 <= cor_resp.cos_v;
            s0 <= cor_resp.sin_v;
          end
          S_COS1: begin
            c1 <= cor_resp.cos_v;
            s1 <= cor_resp.sin_v;
          end
          S_SMX:          dx  <= shr_p[39:0];
          S_SMY:          dy  <= shr_p[39:0];
          S_TMUL:         tmp <= md_resp.result;
          S_TDIV:         hn  <= hn + md_resp.result[15:0];
          S_KMX, S_KMY:   tmp <= md_resp.result;
          S_KDX:          dx  <= md_resp.result[39:0];
          S_KDY:          dy  <= md_resp.result[39:0];
          default: ;
        endcase
      end

      if ((state == S_UPD) && out_free) begin
        pose_x               <= sat_x;
        pose_y               <= sat_y;
        pose_heading         <= hn;
        out_data.new_x       <= sat_x;
        out_data.new_y       <= sat_y;
        out_data.new_heading <= hn;
        out_valid            <= 1'b1;
      end else if (!out_stall) begin
        out_valid            <= 1'b0;
      end
    end
  end

endmodule

### design/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module ddo_cordic #(
  parameter int ITER = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ddo_pkg::cor_req_t   req,
  output ddo_pkg::cor_resp_t  resp
);

  localparam int IW = $clog2(ITER);

  logic                          busy;
  logic                          done;
  logic                          flip;
  logic [IW-1:0]                 i;
  logic signed [ddo_pkg::CW-1:0] x;
  logic signed [ddo_pkg::CW-1:0] y;
  logic signed [ddo_pkg::CW-1:0] z;
  logic signed [ddo_pkg::CW-1:0] atan_v;
  logic signed [15:0]            ang_f;
  logic                          fold;

  assign fold   = (req.angle > 16'sd16384) || (req.angle < -16'sd16384);
  assign ang_f  = fold ? (req.angle ^ 16'sh8000) : req.angle;
  assign atan_v = ddo_pkg::CW'(ddo_pkg::atan_at(5'(i)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        flip <= fold;
        i    <= '0;
        x    <= ddo_pkg::CORDIC_GAIN;
        y    <= '0;
        z    <= {{2{ang_f[15]}}, ang_f, 16'b0};
      end else if (busy) begin
        if (!z[ddo_pkg::CW-1]) begin
          x <= x - (y >>> i);
          y <= y + (x >>> i);
          z <= z - atan_v;
        end else begin
          x <= x + (y >>> i);
          y <= y - (x >>> i);
          z <= z + atan_v;
        end
        i <= i + 1'b1;
        if (i == IW'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.done  = done;
  assign resp.cos_v = flip ? -x : x;
  assign resp.sin_v = flip ? -y : y;

endmodule

### design/ddo_muldiv.sv
// Bit-serial signed multiplier and rounding divider sharing one sequencer.
module ddo_muldiv (
  input  logic               clk,
  input  logic               rst,
  input  ddo_pkg::md_req_t   req,
  output ddo_pkg::md_resp_t  resp
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_PREP = 4'b0010,
    P_RUN  = 4'b0100,
    P_FIN  = 4'b1000
  } phase_t;

  localparam int AW = ddo_pkg::AW;
  localparam int QW = ddo_pkg::QW;

  phase_t                     phase;
  ddo_pkg::op_t               op;
  logic                       neg;
  logic [ddo_pkg::SH_W-1:0]   sh;
  logic [AW-1:0]              ma;
  logic [AW-1:0]              mb;
  logic [AW-1:0]              acc;
  logic [AW-1:0]              rem;
  logic [AW-1:0]              dd;
  logic [QW-1:0]              low;
  logic [QW-1:0]              q;
  logic [5:0]                 cnt;
  logic                       done;
  logic signed [AW-1:0]       result;

  logic [AW-1:0] dd_c;
  logic [AW-1:0] n_c;
  logic [AW-1:0] tr;
  logic [AW-1:0] q_ext;

  assign dd_c  = mb << sh;
  assign n_c   = ma + (dd_c >> 1);
  assign tr    = {rem[AW-2:0], low[QW-1]};
  assign q_ext = AW'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (req.start) begin
            op    <= req.op;
            neg   <= req.a[AW-1] ^ req.b[AW-1];
            ma    <= req.a[AW-1] ? AW'(-req.a) : AW'(req.a);
            mb    <= req.b[AW-1] ? AW'(-req.b) : AW'(req.b);
            sh    <= req.shift;
            phase <= P_PREP;
          end
        end
        P_PREP: begin
          acc   <= '0;
          cnt   <= '0;
          q     <= '0;
          dd    <= dd_c;
          rem   <= n_c >> QW;
          low   <= n_c[QW-1:0];
          phase <= P_RUN;
        end
        P_RUN: begin
          cnt <= cnt + 1'b1;
          if (op == ddo_pkg::OP_MUL) begin
            if (mb[0]) acc <= acc + ma;
            ma <= ma << 1;
            mb <= mb >> 1;
            if (cnt == 6'(ddo_pkg::MBW - 1)) phase <= P_FIN;
          end else begin
            if (tr >= dd) begin
              rem <= tr - dd;
              q   <= {q[QW-2:0], 1'b1};
            end else begin
              rem <= tr;
              q   <= {q[QW-2:0], 1'b0};
            end
            low <= low << 1;
            if (cnt == 6'(QW - 1)) phase <= P_FIN;
          end
        end
        P_FIN: begin
          if (op == ddo_pkg::OP_MUL) begin
            result <= neg ? -$signed(acc) : $signed(acc);
          end else begin
            result <= neg ? -$signed(q_ext) : $signed(q_ext);
          end
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign resp.done   = done;
  assign resp.result = result;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the differential-drive odometry core.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT = 1000000;
  localparam int RAND_ITEMS = 530;
  localparam int PHASES = 8;
  localparam logic [ddo_pkg::IDX_W-1:0] REG_UNUSED = ddo_pkg::REG_START_HEADING + 1'b1;
  localparam logic [ddo_pkg::IDX_W-1:0] REG_TOP    = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [ddo_pkg::IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  ddo_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  ddo_pkg::out_item_t out_data;

  differential_drive_odometry_step_core u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  longint pose_x_m, pose_y_m;
  int pose_h_m;
  int axle_m;
  ddo_pkg::out_item_t pose_q[$];
  int n_err = 0, n_items = 0, n_results = 0, n_turns = 0;
  longint cycles = 0;

  const longint ATAN[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};

  function automatic int wrap_bam(longint v);
    logic [15:0] b;
    b = v[15:0];
    return int'($signed(b));
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_nearest(longint num, longint den, int sh);
    longint unsigned mag, d, q;
    bit neg;
    neg = 1'b0;
    if (den < 0) begin
      den = -den;
      neg = 1'b1;
    end
    if (num < 0) begin
      mag = longint'(-(num + 1)) + 1;
      neg = !neg;
    end else begin
      mag = num;
    end
    d = longint'(den) << sh;
    q = (mag + d / 2) / d;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic rotate(input int ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    x = 326016437;
    y = 0;
    flip = 1'b0;
    if (ang > 16384 || ang < -16384) begin
      ang = wrap_bam(longint'(ang) - 32768);
      flip = 1'b1;
    end
    z = longint'(ang) * 65536;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic advance_pose(input ddo_pkg::in_item_t it, output ddo_pkg::out_item_t res);
    longint l, r, dt, axle, diff, dx, dy, c0, s0, c1, s1, d, dbam, k;
    int nh;
    l = longint'(it.left_speed);
    r = longint'(it.right_speed);
    dt = longint'(it.time_step);
    axle = (axle_m != 0) ? axle_m : 1;
    diff = l - r;
    rotate(pose_h_m, c0, s0);
    if (diff == 0) begin
      d = r * dt;
      dx = (d * c0 + (64'sd1 <<< 44)) >>> 45;
      dy = (d * s0 + (64'sd1 <<< 44)) >>> 45;
    end else begin
      dbam = div_nearest(diff * dt * 64'sd683565276, axle, 32);
      nh = wrap_bam(longint'(pose_h_m) + dbam);
      rotate(nh, c1, s1);
      k = axle * (l + r);
      dx = div_nearest(k * (s1 - s0), diff, 30);
      dy = div_nearest(k * (c0 - c1), diff, 30);
      pose_h_m = nh;
      n_turns++;
    end
    pose_x_m = sat_pos(pose_x_m + dx);
    pose_y_m = sat_pos(pose_y_m + dy);
    res.new_x = pose_x_m[31:0];
    res.new_y = pose_y_m[31:0];
    res.new_heading = pose_h_m[15:0];
  endtask

  // Typed expectation for directed rows, one entry per input transfer in order
  typedef struct {
    bit has_pose;
    ddo_pkg::out_item_t pose;
  } typed_t;

  typed_t typed_q[$];

  always @(posedge clk) begin
    ddo_pkg::out_item_t want, got;
    typed_t tw;
    cycles <= cycles + 1;
    if (rst) begin
      axle_m = 3072;
      pose_x_m = 0;
      pose_y_m = 0;
      pose_h_m = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ddo_pkg::REG_AXLE_LENGTH:   axle_m = int'(cfg_data[15:0]);
          ddo_pkg::REG_START_X:       pose_x_m = longint'($signed(cfg_data));
          ddo_pkg::REG_START_Y:       pose_y_m = longint'($signed(cfg_data));
          ddo_pkg::REG_START_HEADING: pose_h_m = wrap_bam(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_pose(in_data, want);
        if (typed_q.size() != 0) begin
          tw = typed_q.pop_front();
          if (tw.has_pose) want = tw.pose;
        end
        pose_q.push_back(want);
        n_items++;
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        n_results++;
        if (pose_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result transfer %h", got);
        end else begin
          want = pose_q.pop_front();
          if (got.new_x !== want.new_x || got.new_y !== want.new_y ||
              got.new_heading !== want.new_heading) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch result %0d: exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                       n_results, want.new_x, want.new_y, want.new_heading,
                       got.new_x, got.new_y, got.new_heading);
          end
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side stall pattern
  initial begin
    int k;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  typedef struct {
    bit is_cfg;
    logic [ddo_pkg::IDX_W-1:0] idx;
    logic [31:0] val;
    ddo_pkg::in_item_t it;
    bit has_pose;
    ddo_pkg::out_item_t pose;
  } row_t;

  row_t rows[$];

  function automatic row_t mk_item(int l, int r, int dt);
    row_t w;
    w = '{default: '0};
    w.it.left_speed = 16'(l);
    w.it.right_speed = 16'(r);
    w.it.time_step = 16'(dt);
    return w;
  endfunction

  function automatic row_t mk_cfg(logic [ddo_pkg::IDX_W-1:0] idx, logic [31:0] v);
    row_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.idx = idx;
    w.val = v;
    return w;
  endfunction

  function automatic row_t mk_still(int l, int r, logic [31:0] x, logic [31:0] y,
                                    logic [15:0] h);
    row_t w;
    w = mk_item(l, r, 0);
    w.has_pose = 1'b1;
    w.pose = '{x, y, h};
    return w;
  endfunction

  bit fast_in = 1'b0;

  task automatic send(input ddo_pkg::in_item_t it, input bit has_pose,
                      input ddo_pkg::out_item_t pose);
    int g;
    typed_t tw;
    tw.has_pose = has_pose;
    tw.pose = pose;
    typed_q.push_back(tw);
    g = fast_in ? 0 : $urandom_range(0, 17);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [ddo_pkg::IDX_W-1:0] idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 65535) - 32768);
      default: return $urandom;
    endcase
  endfunction

  function automatic ddo_pkg::in_item_t rand_item();
    ddo_pkg::in_item_t it;
    int m;
    m = $urandom_range(0, 9);
    it.left_speed = (m < 5) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
    it.right_speed = ($urandom_range(0, 3) == 0) ? it.left_speed :
                     (m < 7) ? 16'($urandom) :
                     16'(it.left_speed + $urandom_range(0, 63) - 32);
    case ($urandom_range(0, 9))
      0: it.time_step = 16'd0;
      1, 2, 3: it.time_step = 16'($urandom);
      default: it.time_step = 16'($urandom_range(0, 4095));
    endcase
    return it;
  endfunction

  initial begin
    logic [15:0] ax;
    rows.push_back(mk_still(0, 0, 32'd0, 32'd0, 16'd0));
    rows.push_back(mk_item(32767, 32767, 65535));
    rows.push_back(mk_item(-32768, -32768, 65535));
    rows.push_back(mk_item(32767, -32768, 65535));
    rows.push_back(mk_item(-32768, 32767, 65535));
    rows.push_back(mk_item(1, 0, 1));
    rows.push_back(mk_item(0, -1, 65535));
    rows.push_back(mk_cfg(ddo_pkg::REG_AXLE_LENGTH, 32'd0));
    rows.push_back(mk_item(256, -256, 40000));
    rows.push_back(mk_cfg(ddo_pkg::REG_AXLE_LENGTH, 32'd65535));
    rows.push_back(mk_item(-32768, 32767, 65535));
    rows.push_back(mk_cfg(ddo_pkg::REG_AXLE_LENGTH, 32'd1));
    rows.push_back(mk_item(100, 99, 65535));
    rows.push_back(mk_cfg(ddo_pkg::REG_START_X, 32'h7FFFFF00));
    rows.push_back(mk_cfg(ddo_pkg::REG_START_Y, 32'h80000000));
    rows.push_back(mk_cfg(ddo_pkg::REG_START_HEADING, 32'hFFFF8000));
    rows.push_back(mk_still(5, -5, 32'h7FFFFF00, 32'h80000000, 16'h8000));
    rows.push_back(mk_cfg(ddo_pkg::REG_START_HEADING, 32'd0));
    rows.push_back(mk_item(32767, 32767, 65535));
    rows.push_back(mk_cfg(ddo_pkg::REG_START_HEADING, 32'hFFFFC000));
    rows.push_back(mk_item(32767, 32767, 65535));
    rows.push_back(mk_cfg(ddo_pkg::REG_START_HEADING, 32'd32767));
    rows.push_back(mk_cfg(REG_UNUSED, 32'hFFFFFFFF));
    rows.push_back(mk_cfg(REG_TOP, 32'h12345678));
    rows.push_back(mk_item(-1, -1, 12345));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        put_reg(rows[i].idx, rows[i].val);
        cfg_write <= 1'b0;
      end else begin
        send(rows[i].it, rows[i].has_pose, rows[i].pose);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p % 4)
        0: ax = 16'd3072;
        1: ax = 16'd1;
        2: ax = 16'd65535;
        default: ax = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
      endcase
      put_reg(ddo_pkg::REG_START_HEADING, $urandom);
      put_reg(ddo_pkg::REG_AXLE_LENGTH, 32'(ax));
      put_reg(ddo_pkg::REG_START_X, pick_pos());
      put_reg(ddo_pkg::REG_START_Y, pick_pos());
      cfg_write <= 1'b0;
      fast_in = (p % 3 == 1);
      for (int j = 0; j < RAND_ITEMS / PHASES; j++) begin
        if (j % 20 == 0) fast_in = ($urandom_range(0, 2) == 0);
        send(rand_item(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d pose updates (%0d turns) over %0d register settings",
             n_items, n_turns, PHASES + 1);
    $display("%0d results checked, %0d mismatches", n_results, n_err);
    if (n_err == 0 && pose_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
design/ddo_pkg.sv
design/ddo_cordic.sv
design/ddo_muldiv.sv
design/differential_drive_odometry_step_core.sv
tb/tb_top.sv
